// ----- rtl/job_sequencing_with_deadlines_core_assert.svh -----
// Assertion macros used by the job sequencing datapath
`ifndef JOB_SEQUENCING_WITH_DEADLINES_CORE_ASSERT_SVH
`define JOB_SEQUENCING_WITH_DEADLINES_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet in reset
`define JSD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("job sequencing: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet in reset
`define JSD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("job sequencing: next-cycle check failed");

`endif

// ----- rtl/jsd_pkg.sv -----
// Package: types, constants and control structs of the job sequencer
`timescale 1ns / 1ps
package jsd_pkg;

    localparam int MAX_JOBS_DEF = 32;
    localparam int SLOT_COUNT   = 32;
    localparam int SLOT_W       = 5;
    localparam int K_W          = 6;
    localparam int ID_W         = 16;
    localparam int DL_W         = 8;
    localparam int PR_W         = 16;
    localparam int JOB_W        = ID_W + DL_W + PR_W;
    localparam int TOTAL_W      = 21;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_I,
        S_SORT_IW,
        S_SORT_JR,
        S_SORT_JC,
        S_ASG_RD,
        S_ASG_LD,
        S_ASG_SRCH,
        S_EMIT_SCAN,
        S_EMIT_RD
    } state_t;

    typedef enum logic [1:0] {
        RD_I,
        RD_J,
        RD_SLOT
    } rd_sel_t;

    typedef struct packed {
        logic    ld_ready;
        logic    i_clr;
        logic    i_inc;
        logic    j_set;
        logic    j_inc;
        logic    k_clr;
        logic    k_inc;
        logic    k_dec;
        logic    k_horizon;
        rd_sel_t rd_sel;
        logic    a_load;
        logic    wr_i;
        logic    swap;
        logic    take;
        logic    out_load;
        logic    batch_clr;
    } cmd_t;

    typedef struct packed {
        logic i_end;
        logic i_last;
        logic j_end;
        logic greater;
        logic k_zero;
        logic slot_free;
        logic k_end;
        logic k_taken;
        logic out_full;
    } sts_t;

endpackage

// ----- rtl/jsd_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module jsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/jsd_ctrl.sv -----
// Controller: sequences loading, exchange sort, slot assignment and emission
`timescale 1ns / 1ps
module jsd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          last_job,
    input  jsd_pkg::sts_t sts,
    output jsd_pkg::cmd_t cmd
);
    import jsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && last_job)
                begin
                    state_next = S_SORT_I;
                end
            end
            S_SORT_I:    state_next = sts.i_last ? S_ASG_RD : S_SORT_IW;
            S_SORT_IW:   state_next = S_SORT_JR;
            S_SORT_JR:   state_next = sts.j_end ? S_SORT_I : S_SORT_JC;
            S_SORT_JC:   state_next = S_SORT_JR;
            S_ASG_RD:    state_next = sts.i_end ? S_EMIT_SCAN : S_ASG_LD;
            S_ASG_LD:    state_next = S_ASG_SRCH;
            S_ASG_SRCH:
            begin
                if (sts.k_zero || sts.slot_free)
                begin
                    state_next = S_ASG_RD;
                end
            end
            S_EMIT_SCAN:
            begin
                if (sts.k_end)
                begin
                    state_next = S_LOAD;
                end
                else if (sts.k_taken && !sts.out_full)
                begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:   state_next = S_EMIT_SCAN;
            default:     state_next = S_LOAD;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_I;
        unique case (state_reg)
            S_LOAD:
            begin
                cmd.ld_ready = 1'b1;
                cmd.i_clr    = 1'b1;
            end
            S_SORT_I:
            begin
                cmd.rd_sel = RD_I;
                cmd.i_clr  = sts.i_last;
            end
            S_SORT_IW:
            begin
                cmd.a_load = 1'b1;
                cmd.j_set  = 1'b1;
            end
            S_SORT_JR:
            begin
                cmd.rd_sel = RD_J;
                cmd.wr_i   = sts.j_end;
                cmd.i_inc  = sts.j_end;
            end
            S_SORT_JC:
            begin
                cmd.swap  = sts.greater;
                cmd.j_inc = 1'b1;
            end
            S_ASG_RD:
            begin
                cmd.rd_sel = RD_I;
                cmd.k_clr  = sts.i_end;
            end
            S_ASG_LD:
            begin
                cmd.k_horizon = 1'b1;
            end
            S_ASG_SRCH:
            begin
                if (sts.k_zero)
                begin
                    cmd.i_inc = 1'b1;
                end
                else if (sts.slot_free)
                begin
                    cmd.take  = 1'b1;
                    cmd.i_inc = 1'b1;
                end
                else
                begin
                    cmd.k_dec = 1'b1;
                end
            end
            S_EMIT_SCAN:
            begin
                cmd.rd_sel = RD_SLOT;
                if (sts.k_end)
                begin
                    cmd.batch_clr = 1'b1;
                end
                else if (!sts.k_taken)
                begin
                    cmd.k_inc = 1'b1;
                end
            end
            S_EMIT_RD:
            begin
                cmd.out_load = 1'b1;
                cmd.k_inc    = 1'b1;
            end
            default:
            begin
                cmd.rd_sel = RD_I;
            end
        endcase
    end

endmodule

// ----- rtl/jsd_dp.sv -----
// Datapath: job store, counters, slot table and output register
`timescale 1ns / 1ps
module jsd_dp #(
    parameter int MAX_JOBS = jsd_pkg::MAX_JOBS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  jsd_pkg::cmd_t               cmd,
    output jsd_pkg::sts_t               sts,
    input  logic                        in_valid,
    input  logic [jsd_pkg::ID_W-1:0]    job_id,
    input  logic [jsd_pkg::DL_W-1:0]    deadline,
    input  logic [jsd_pkg::PR_W-1:0]    profit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jsd_pkg::SLOT_W-1:0]  slot_index,
    output logic [jsd_pkg::ID_W-1:0]    sched_job_id,
    output logic [jsd_pkg::DL_W-1:0]    sched_deadline,
    output logic [jsd_pkg::PR_W-1:0]    sched_profit,
    output logic [jsd_pkg::TOTAL_W-1:0] running_total,
    output logic                        overflow,
    output logic                        last_result
);
    import jsd_pkg::*;
    `include "job_sequencing_with_deadlines_core_assert.svh"

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      i_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [K_W-1:0]        k_reg;
    logic [K_W-1:0]        k_next;
    logic [JOB_W-1:0]      a_reg;
    logic [SLOT_COUNT-1:0] taken_reg;
    logic [IDX_W-1:0]      slot_job_reg [SLOT_COUNT];
    logic [TOTAL_W-1:0]    total_reg;
    logic [TOTAL_W-1:0]    total_next;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [JOB_W-1:0]      job_out_reg;
    logic [TOTAL_W-1:0]    tot_out_reg;
    logic                  ovf_out_reg;
    logic                  last_out_reg;

    logic                  accept;
    logic                  cnt_full;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [JOB_W-1:0]      ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [JOB_W-1:0]      ram_rdata;
    logic [DL_W-1:0]       cnt_dl;
    logic [DL_W-1:0]       hz_a;
    logic [K_W-1:0]        horizon;
    logic [SLOT_W-1:0]     k_lo;
    logic [SLOT_W-1:0]     k_m1;
    logic [SLOT_COUNT-1:0] later;
    logic [CNT_W:0]        i_plus1;

    assign accept   = in_valid && cmd.ld_ready;
    assign cnt_full = (cnt_reg == CNT_W'(MAX_JOBS));
    assign k_lo     = k_reg[SLOT_W-1:0];
    assign k_m1     = SLOT_W'(k_reg - K_W'(1));
    assign i_plus1  = {1'b0, i_reg} + (CNT_W + 1)'(1);

    // Select store write source
    always_comb
    begin
        ram_we    = (accept && !cnt_full) || cmd.wr_i || cmd.swap;
        ram_wdata = a_reg;
        ram_waddr = j_reg[IDX_W-1:0];
        if (accept)
        begin
            ram_wdata = {job_id, deadline, profit};
            ram_waddr = cnt_reg[IDX_W-1:0];
        end
        else if (cmd.wr_i)
        begin
            ram_waddr = i_reg[IDX_W-1:0];
        end
    end

    // Select store read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_I:    ram_raddr = i_reg[IDX_W-1:0];
            RD_J:    ram_raddr = j_reg[IDX_W-1:0];
            RD_SLOT: ram_raddr = slot_job_reg[k_lo];
            default: ram_raddr = i_reg[IDX_W-1:0];
        endcase
    end

    jsd_ram #(
        .WIDTH (JOB_W),
        .DEPTH (MAX_JOBS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Horizon: min(count, deadline, slot count)
    always_comb
    begin
        cnt_dl = DL_W'(cnt_reg);
        hz_a   = (cnt_dl < ram_rdata[PR_W +: DL_W]) ? cnt_dl : ram_rdata[PR_W +: DL_W];
        if (hz_a > DL_W'(SLOT_COUNT))
        begin
            horizon = K_W'(SLOT_COUNT);
        end
        else
        begin
            horizon = K_W'(hz_a);
        end
    end

    // Slot counter
    always_comb
    begin
        k_next = k_reg;
        if (cmd.k_clr)
        begin
            k_next = '0;
        end
        else if (cmd.k_horizon)
        begin
            k_next = horizon;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - K_W'(1);
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + K_W'(1);
        end
    end

    assign total_next = total_reg + TOTAL_W'(ram_rdata[PR_W-1:0]);
    assign later      = (taken_reg >> k_lo) >> 1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            taken_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            // Load word or flag a dropped one
            if (accept)
            begin
                if (cnt_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            if (cmd.i_clr)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_inc)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end
            if (cmd.j_set)
            begin
                j_reg <= CNT_W'(i_plus1);
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + CNT_W'(1);
            end
            if (cmd.take)
            begin
                taken_reg[k_m1] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                total_reg <= total_next;
            end
            // Return batch state to rest
            if (cmd.batch_clr)
            begin
                cnt_reg   <= '0;
                ovf_reg   <= 1'b0;
                taken_reg <= '0;
                total_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.a_load || cmd.swap)
        begin
            a_reg <= ram_rdata;
        end
        if (cmd.take)
        begin
            slot_job_reg[k_m1] <= i_reg[IDX_W-1:0];
        end
        if (cmd.out_load)
        begin
            slot_reg     <= k_lo;
            job_out_reg  <= ram_rdata;
            tot_out_reg  <= total_next;
            ovf_out_reg  <= ovf_reg;
            last_out_reg <= (later == '0);
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.i_end     = ({1'b0, i_reg} >= {1'b0, cnt_reg});
        sts.i_last    = (i_plus1 >= {1'b0, cnt_reg});
        sts.j_end     = (j_reg >= cnt_reg);
        sts.greater   = (ram_rdata[PR_W-1:0] > a_reg[PR_W-1:0]);
        sts.k_zero    = (k_reg == '0);
        sts.slot_free = !taken_reg[k_m1];
        sts.k_end     = k_reg[K_W-1];
        sts.k_taken   = taken_reg[k_lo];
        sts.out_full  = out_valid_reg;
    end

    assign out_valid      = out_valid_reg;
    assign slot_index     = slot_reg;
    assign sched_job_id   = job_out_reg[JOB_W-1 -: ID_W];
    assign sched_deadline = job_out_reg[PR_W +: DL_W];
    assign sched_profit   = job_out_reg[PR_W-1:0];
    assign running_total  = tot_out_reg;
    assign overflow       = ovf_out_reg;
    assign last_result    = last_out_reg;

    // Never overwrite a word still waiting at the output
    `JSD_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg)
    // Only claim a free slot inside the horizon
    `JSD_ASSERT_IMP(a_take_free, cmd.take, (k_reg != '0) && !taken_reg[k_m1])
    // A word arriving at a full store marks the batch
    `JSD_ASSERT_NXT(a_full_flags, accept && cnt_full && !cmd.batch_clr, ovf_reg)

endmodule

// ----- rtl/job_sequencing_with_deadlines_core.sv -----
// Top level of the greedy job sequencer with deadlines
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | job_id, deadline, profit, last_job
//  out     | out_valid / out_ready| slot_index, sched_job_id, sched_deadline,
//          |                      | sched_profit, running_total, overflow, last_result
//
// A non-final word is accepted in the load state. The final word starts the batch:
// an exchange sort (a read state and a compare state per pair, one store read port),
// then per job a read, a horizon load and a search over occupied slots, then a scan
// and a read per emitted slot and a scan step per empty slot over 32 slots. No clearing
// pass after reset. in_ready is low from the final word until emission ends; a stalled
// output holds the scan until its word is taken.
`timescale 1ns / 1ps
module job_sequencing_with_deadlines_core #(
    parameter int MAX_JOBS = jsd_pkg::MAX_JOBS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [jsd_pkg::ID_W-1:0]    job_id,
    input  logic [jsd_pkg::DL_W-1:0]    deadline,
    input  logic [jsd_pkg::PR_W-1:0]    profit,
    input  logic                        last_job,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jsd_pkg::SLOT_W-1:0]  slot_index,
    output logic [jsd_pkg::ID_W-1:0]    sched_job_id,
    output logic [jsd_pkg::DL_W-1:0]    sched_deadline,
    output logic [jsd_pkg::PR_W-1:0]    sched_profit,
    output logic [jsd_pkg::TOTAL_W-1:0] running_total,
    output logic                        overflow,
    output logic                        last_result
);
    import jsd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign in_ready = cmd.ld_ready;

    jsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_job (last_job),
        .sts      (sts),
        .cmd      (cmd)
    );

    jsd_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_valid       (in_valid),
        .job_id         (job_id),
        .deadline       (deadline),
        .profit         (profit),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot_index     (slot_index),
        .sched_job_id   (sched_job_id),
        .sched_deadline (sched_deadline),
        .sched_profit   (sched_profit),
        .running_total  (running_total),
        .overflow       (overflow),
        .last_result    (last_result)
    );

endmodule

// ----- test/job_sequencing_with_deadlines_core_tb.sv -----
// Testbench for the greedy job sequencer: directed and random batches against a schedule model
`timescale 1ns / 1ps
module job_sequencing_with_deadlines_core_tb;
    import jsd_pkg::*;

    localparam int STORE_DEPTH = MAX_JOBS_DEF;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] dl;
        logic [PR_W-1:0] pr;
    } job_rec_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [ID_W-1:0]    id;
        logic [DL_W-1:0]    dl;
        logic [PR_W-1:0]    pr;
        logic [TOTAL_W-1:0] total;
        logic               ovf;
        logic               last;
    } slot_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [ID_W-1:0]      job_id = '0;
    logic [DL_W-1:0]      deadline = '0;
    logic [PR_W-1:0]      profit = '0;
    logic                 last_job = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SLOT_W-1:0]    slot_index;
    logic [ID_W-1:0]      sched_job_id;
    logic [DL_W-1:0]      sched_deadline;
    logic [PR_W-1:0]      sched_profit;
    logic [TOTAL_W-1:0]   running_total;
    logic                 overflow;
    logic                 last_result;

    // model state
    job_rec_t   pending_jobs[STORE_DEPTH];
    int         pending_count = 0;
    logic       pending_ovf = 1'b0;
    slot_word_t schedule_q[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  jobs_sent = 0;
    int  batches_sent = 0;
    int  slots_seen = 0;
    int  ovf_batches = 0;
    int  burst_left = 0;

    job_sequencing_with_deadlines_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .job_id(job_id), .deadline(deadline), .profit(profit), .last_job(last_job),
        .out_valid(out_valid), .out_ready(out_ready),
        .slot_index(slot_index), .sched_job_id(sched_job_id),
        .sched_deadline(sched_deadline), .sched_profit(sched_profit),
        .running_total(running_total), .overflow(overflow), .last_result(last_result)
    );

    always #5 clk = ~clk;

    // Store one job and, on the final word, build the expected schedule
    task automatic schedule_batch(input job_rec_t jb, input logic is_last);
        job_rec_t   tmp;
        logic       taken[SLOT_COUNT];
        int         owner[SLOT_COUNT];
        int         horizon;
        int         n;
        logic [TOTAL_W-1:0] sum;
        int         last_slot;
        slot_word_t w;
        if (pending_count < STORE_DEPTH) begin
            pending_jobs[pending_count] = jb;
            pending_count++;
        end else begin
            pending_ovf = 1'b1;
        end
        if (!is_last)
            return;
        n = pending_count;
        // exchange sort, descending profit, strict compare
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (pending_jobs[j].pr > pending_jobs[i].pr) begin
                    tmp = pending_jobs[i];
                    pending_jobs[i] = pending_jobs[j];
                    pending_jobs[j] = tmp;
                end
        for (int k = 0; k < SLOT_COUNT; k++) taken[k] = 1'b0;
        // take the latest free slot under each job's horizon
        for (int i = 0; i < n; i++) begin
            horizon = (n < pending_jobs[i].dl) ? n : pending_jobs[i].dl;
            if (horizon > SLOT_COUNT) horizon = SLOT_COUNT;
            for (int k = horizon; k > 0; k--)
                if (!taken[k-1]) begin
                    taken[k-1] = 1'b1;
                    owner[k-1] = i;
                    break;
                end
        end
        last_slot = -1;
        for (int k = 0; k < SLOT_COUNT; k++) if (taken[k]) last_slot = k;
        sum = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
            if (taken[k]) begin
                sum += pending_jobs[owner[k]].pr;
                w.slot  = k[SLOT_W-1:0];
                w.id    = pending_jobs[owner[k]].id;
                w.dl    = pending_jobs[owner[k]].dl;
                w.pr    = pending_jobs[owner[k]].pr;
                w.total = sum;
                w.ovf   = pending_ovf;
                w.last  = (k == last_slot);
                schedule_q.push_back(w);
            end
        if (pending_ovf) ovf_batches++;
        batches_sent++;
        pending_count = 0;
        pending_ovf = 1'b0;
    endtask

    // Send one word in bursts with random gaps, then record it in the model
    task automatic send_job(input logic [ID_W-1:0] id, input logic [DL_W-1:0] dl,
                            input logic [PR_W-1:0] pr, input logic is_last);
        job_rec_t jb;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        job_id   <= id;
        deadline <= dl;
        profit   <= pr;
        last_job <= is_last;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        jb.id = id; jb.dl = dl; jb.pr = pr;
        schedule_batch(jb, is_last);
        jobs_sent++;
    endtask

    // Drop valid once a test has handed over its last word
    task automatic idle_sender();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    // Random batch of n jobs; one style in three uses a narrow profit range to force ties
    task automatic random_batch(input int n);
        logic [PR_W-1:0] pr;
        logic [DL_W-1:0] dl;
        int style;
        style = $urandom_range(0, 2);
        for (int i = 0; i < n; i++) begin
            pr = (style == 0) ? PR_W'($urandom_range(0, 3)) : PR_W'($urandom);
            dl = ($urandom_range(0, 3) == 0) ? DL_W'($urandom)
                                             : DL_W'($urandom_range(0, n + 2));
            send_job(ID_W'($urandom), dl, pr, i == n - 1);
        end
    endtask

    task automatic test_edges();
        // lone job with zero deadline schedules nothing
        send_job(16'h1234, 8'd0, 16'hFFFF, 1'b1);
        // extremes of every field
        send_job(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
        send_job(16'h0000, 8'd1, 16'h0000, 1'b1);
        // deadlines past the batch size are cut to the count
        send_job(16'hAAAA, 8'd200, 16'd10, 1'b0);
        send_job(16'h5555, 8'd255, 16'd20, 1'b0);
        send_job(16'h0F0F, 8'd0, 16'd30, 1'b1);
        idle_sender();
    endtask

    task automatic test_ties();
        // equal profits fall in exchange-sort order
        send_job(16'd1, 8'd2, 16'd7, 1'b0);
        send_job(16'd2, 8'd1, 16'd7, 1'b0);
        send_job(16'd3, 8'd2, 16'd9, 1'b0);
        send_job(16'd4, 8'd1, 16'd7, 1'b0);
        send_job(16'd5, 8'd3, 16'd7, 1'b1);
        // all jobs contend for slot zero
        for (int i = 0; i < 6; i++)
            send_job(ID_W'(100 + i), 8'd1, PR_W'(50 - i), i == 5);
        idle_sender();
    endtask

    task automatic test_full_store();
        // last word arrives with the store full
        for (int i = 0; i < STORE_DEPTH + 3; i++)
            send_job(ID_W'($urandom), DL_W'($urandom_range(0, 40)), PR_W'($urandom),
                     i == STORE_DEPTH + 2);
        // exactly full, no overflow
        random_batch(STORE_DEPTH);
        idle_sender();
    endtask

    task automatic test_random();
        int n;
        while (jobs_sent < 430) begin
            if ($urandom_range(0, 19) == 0) n = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 4);
            else n = $urandom_range(1, 10);
            random_batch(n);
        end
        idle_sender();
    endtask

    // Receiver: pattern of always ready, random stalls and long stalls
    always @(posedge clk) begin
        case ((cycle_count / 97) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ((cycle_count % 11) < 3);
            default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Sample mid-cycle, check at the edge that takes the word
    logic       take_word = 1'b0;
    slot_word_t seen_word;
    always @(negedge clk) begin
        take_word <= out_valid && out_ready;
        seen_word <= {slot_index, sched_job_id, sched_deadline, sched_profit,
                      running_total, overflow, last_result};
    end

    always @(posedge clk) begin
        slot_word_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && take_word) begin
            slots_seen++;
            if (schedule_q.size() == 0) begin
                $error("unexpected slot word %0d", seen_word.slot);
                fail_count++;
            end else begin
                want = schedule_q.pop_front();
                if (want.slot != seen_word.slot) begin
                    $error("slot_index: expected %0d, got %0d", want.slot, seen_word.slot);
                    fail_count++;
                end
                if (want.id != seen_word.id) begin
                    $error("sched_job_id: expected %0h, got %0h", want.id, seen_word.id);
                    fail_count++;
                end
                if (want.dl != seen_word.dl) begin
                    $error("sched_deadline: expected %0d, got %0d", want.dl, seen_word.dl);
                    fail_count++;
                end
                if (want.pr != seen_word.pr) begin
                    $error("sched_profit: expected %0d, got %0d", want.pr, seen_word.pr);
                    fail_count++;
                end
                if (want.total != seen_word.total) begin
                    $error("running_total: expected %0d, got %0d", want.total, seen_word.total);
                    fail_count++;
                end
                if (want.ovf != seen_word.ovf) begin
                    $error("overflow: expected %0b, got %0b", want.ovf, seen_word.ovf);
                    fail_count++;
                end
                if (want.last != seen_word.last) begin
                    $error("last_result: expected %0b, got %0b", want.last, seen_word.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL job_sequencing_with_deadlines_core");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_ties();
        test_full_store();
        test_random();
        while (schedule_q.size() != 0) @(posedge clk);
        repeat (3000) @(posedge clk);
        if (schedule_q.size() != 0) begin
            $error("%0d slot words never arrived", schedule_q.size());
            fail_count++;
        end
        $display("Sent %0d jobs in %0d batches, %0d with a full store.",
                 jobs_sent, batches_sent, ovf_batches);
        $display("Checked %0d scheduled slots with stalls on both sides.", slots_seen);
        if (fail_count == 0)
            $display("PASS job_sequencing_with_deadlines_core");
        else
            $display("FAIL job_sequencing_with_deadlines_core");
        $finish;
    end

endmodule
